### sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define CHK_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// same, on the usual clk and rst_n of the enclosing module
`define CHK_ASSERT_DEF(lbl, prop, msg) \
  `CHK_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

### sv/uuid7_pkg.sv
// types, constants and helper functions of the uuid v7 text generator
package uuid7_pkg;

  typedef struct packed {
    logic [47:0] wall_ms;
    logic [63:0] sequence_req;
  } in_word_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic [5:0] char_index;
    logic       last;
  } out_word_t;

  // data that rides along the hash pipeline
  typedef struct packed {
    logic [47:0] wall_ms;
    logic [63:0] wa;
  } side_t;

  localparam logic [63:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_C1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_C2  = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] WB_KEY  = 64'hD1B5_4A32_D192_ED03;

  localparam logic [3:0] VERSION_NIB  = 4'h7;
  localparam logic [1:0] VARIANT_BITS = 2'b10;

  localparam logic [5:0] LAST_INDEX = 6'd35;
  localparam logic [5:0] DASH_POS0  = 6'd8;
  localparam logic [5:0] DASH_POS1  = 6'd13;
  localparam logic [5:0] DASH_POS2  = 6'd18;
  localparam logic [5:0] DASH_POS3  = 6'd23;

  localparam logic [6:0] DASH_CHAR  = 7'h2D;
  localparam logic [6:0] ZERO_CHAR  = 7'h30;
  localparam logic [6:0] ALPHA_BASE = 7'h57;  // 'a' minus ten

  function automatic logic is_dash(input logic [5:0] pos);
    return (pos == DASH_POS0) || (pos == DASH_POS1) ||
           (pos == DASH_POS2) || (pos == DASH_POS3);
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] base;
    base = (nib < 4'd10) ? ZERO_CHAR : ALPHA_BASE;
    return base + {3'b000, nib};
  endfunction

endpackage

### sv/uuid_v7_text_generator_core.sv
// an accepted word passes the 12 hash stages, then streams out of the serializer,
// which reloads as its last character leaves; the pipeline fills up to 12 words
// and holds while its last stage has a word waiting; synchronous active-low rst_n
// clears valid bits, serializer busy/position and salt to zero; the user is to
// write salt via cfg_wr_en / cfg_wr_data only while idle; the block lacks a check
module uuid_v7_text_generator_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words: timestamp and sequence
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uuid7_pkg::in_word_t  in_word,
  // output words: one text character each
  output logic                 out_valid,
  input  logic                 out_ready,
  output uuid7_pkg::out_word_t out_word,
  // salt register write
  input  logic                 cfg_wr_en,
  input  logic [63:0]          cfg_wr_data
);
  import uuid7_pkg::*;

  logic [63:0] salt_r;
  logic        ce;
  logic        hash_vld;
  logic [63:0] hash_prod;
  side_t       hash_side;
  logic        ser_take;

  // salt register, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_r <= '0;
    end else if (cfg_wr_en) begin
      salt_r <= cfg_wr_data;
    end
  end

  // whole pipeline moves together; it holds only when its last stage has a
  // finished word that the serializer cannot take yet
  assign ce       = !hash_vld || ser_take;
  assign in_ready = ce;

  uuid7_hash u_hash (
    .clk,
    .rst_n,
    .ce,
    .in_vld   (in_valid),
    .in_word  (in_word),
    .salt     (salt_r),
    .out_vld  (hash_vld),
    .out_prod (hash_prod),
    .out_side (hash_side)
  );

  // serializer holds one finished identifier and steps through its 36 characters;
  // it reloads on the same edge the last character leaves
  uuid7_serializer u_ser (
    .clk,
    .rst_n,
    .pipe_vld  (hash_vld),
    .pipe_prod (hash_prod),
    .pipe_side (hash_side),
    .pipe_take (ser_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

### sv/uuid7_mul64.sv
// two-stage 64x64 multiplier keeping the low 64 bits, built from 32-bit partial products
module uuid7_mul64 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ce,
  input  logic                 in_vld,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  input  uuid7_pkg::side_t     side_in,
  output logic                 out_vld,
  output logic [63:0]          prod,
  output uuid7_pkg::side_t     side_out
);
  import uuid7_pkg::*;

  logic [63:0] pp_ll_r, pp_ll_nxt;
  logic [31:0] pp_lh_r, pp_lh_nxt;
  logic [31:0] pp_hl_r, pp_hl_nxt;
  logic        vld1_r;
  side_t       side1_r;

  logic [63:0] prod_r, prod_nxt;
  logic        vld2_r;
  side_t       side2_r;

  // cross products only matter modulo 2^32
  always_comb begin
    pp_ll_nxt = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    pp_lh_nxt = a[31:0] * b[63:32];
    pp_hl_nxt = a[63:32] * b[31:0];
  end

  assign prod_nxt = pp_ll_r + {pp_lh_r + pp_hl_r, 32'h0000_0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (ce) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      side1_r <= side_in;
      prod_r  <= prod_nxt;
      side2_r <= side1_r;
    end
  end

  assign out_vld  = vld2_r;
  assign prod     = prod_r;
  assign side_out = side2_r;

endmodule

### sv/uuid7_hash.sv
// twelve-stage pipeline: sequence scramble and two splitmix64 finalizer rounds
module uuid7_hash (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ce,
  input  logic                 in_vld,
  input  uuid7_pkg::in_word_t  in_word,
  input  logic [63:0]          salt,
  output logic                 out_vld,
  output logic [63:0]          out_prod,
  output uuid7_pkg::side_t     out_side
);
  import uuid7_pkg::*;

  side_t       side_in;
  logic        m0_vld, m1_vld, m2_vld, m3_vld;
  logic [63:0] m0_prod, m1_prod, m2_prod, m3_prod;
  side_t       m0_side, m1_side, m2_side, m3_side;

  logic        vld1_r, vld2_r;
  logic [63:0] v1_r, v1_nxt;
  logic [63:0] v2_r, v2_nxt;
  logic [63:0] wa;
  side_t       side1_r, side2_r, side2_nxt;

  assign side_in = '{wall_ms: in_word.wall_ms, wa: '0};

  uuid7_mul64 u_mul0 (
    .clk, .rst_n, .ce, .in_vld(in_vld), .a(in_word.sequence_req), .b(GOLDEN),
    .side_in(side_in), .out_vld(m0_vld), .prod(m0_prod), .side_out(m0_side)
  );

  // first finalizer: add
  assign v1_nxt = (salt ^ m0_prod) + GOLDEN;

  uuid7_mul64 u_mul1 (
    .clk, .rst_n, .ce, .in_vld(vld1_r), .a(v1_r ^ (v1_r >> 30)), .b(MIX_C1),
    .side_in(side1_r), .out_vld(m1_vld), .prod(m1_prod), .side_out(m1_side)
  );

  uuid7_mul64 u_mul2 (
    .clk, .rst_n, .ce, .in_vld(m1_vld), .a(m1_prod ^ (m1_prod >> 27)), .b(MIX_C2),
    .side_in(m1_side), .out_vld(m2_vld), .prod(m2_prod), .side_out(m2_side)
  );

  // word a done, second finalizer starts
  always_comb begin
    wa        = m2_prod ^ (m2_prod >> 31);
    v2_nxt    = (wa ^ WB_KEY) + GOLDEN;
    side2_nxt = '{wall_ms: m2_side.wall_ms, wa: wa};
  end

  uuid7_mul64 u_mul3 (
    .clk, .rst_n, .ce, .in_vld(vld2_r), .a(v2_r ^ (v2_r >> 30)), .b(MIX_C1),
    .side_in(side2_r), .out_vld(m3_vld), .prod(m3_prod), .side_out(m3_side)
  );

  uuid7_mul64 u_mul4 (
    .clk, .rst_n, .ce, .in_vld(m3_vld), .a(m3_prod ^ (m3_prod >> 27)), .b(MIX_C2),
    .side_in(m3_side), .out_vld(out_vld), .prod(out_prod), .side_out(out_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (ce) begin
      vld1_r <= m0_vld;
      vld2_r <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      v1_r    <= v1_nxt;
      side1_r <= m0_side;
      v2_r    <= v2_nxt;
      side2_r <= side2_nxt;
    end
  end

endmodule

### sv/uuid7_serializer.sv
// packs the 16 identifier bytes and streams them out as 36 characters: 32 hex digits and four dashes
module uuid7_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pipe_vld,
  input  logic [63:0]          pipe_prod,
  input  uuid7_pkg::side_t     pipe_side,
  output logic                 pipe_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uuid7_pkg::out_word_t out_word
);
  import uuid7_pkg::*;

  logic         busy_r, busy_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [127:0] nib_r, nib_nxt;
  logic [63:0]  wb;
  logic [127:0] packed_bytes;
  logic         at_last, dash, step;

  always_comb begin
    wb = pipe_prod ^ (pipe_prod >> 31);
    packed_bytes = {pipe_side.wall_ms,
                    VERSION_NIB, pipe_side.wa[11:8], pipe_side.wa[7:0],
                    VARIANT_BITS, pipe_side.wa[21:16], pipe_side.wa[31:24],
                    wb[7:0], wb[15:8], wb[23:16], wb[31:24], wb[39:32], wb[47:40]};
  end

  assign at_last   = (pos_r == LAST_INDEX);
  assign dash      = is_dash(pos_r);
  assign step      = busy_r && out_ready;
  assign pipe_take = pipe_vld && (!busy_r || (out_ready && at_last));

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    nib_nxt  = nib_r;
    if (pipe_take) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
      nib_nxt  = packed_bytes;
    end else if (step) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 6'd1;
        if (!dash) begin
          nib_nxt = {nib_r[123:0], 4'h0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nib_r <= nib_nxt;
  end

  assign out_valid           = busy_r;
  assign out_word.text_char  = dash ? DASH_CHAR : hex_char(nib_r[127:124]);
  assign out_word.char_index = pos_r;
  assign out_word.last       = at_last;

endmodule

### sv/uuid7_checker.sv
// port-level checks on the character stream of the uuid v7 text generator
`include "assert_macros.svh"

module uuid7_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  uuid7_pkg::out_word_t out_word
);
  import uuid7_pkg::*;

  `CHK_ASSERT_DEF(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled output word changed")
  `CHK_ASSERT_DEF(a_last_pos, out_valid && out_word.last |-> out_word.char_index == LAST_INDEX, "last flag off the final position")
  `CHK_ASSERT_DEF(a_dash_pos, out_valid && (out_word.char_index == DASH_POS0 || out_word.char_index == DASH_POS1 || out_word.char_index == DASH_POS2 || out_word.char_index == DASH_POS3) |-> out_word.text_char == DASH_CHAR, "missing dash in layout")
  `CHK_ASSERT_DEF(a_index_step, out_valid && out_ready && !out_word.last |=> out_valid && out_word.char_index == $past(out_word.char_index) + 6'd1, "character index did not advance by one")
  `CHK_ASSERT_DEF(a_version, out_valid && out_word.char_index == 6'd14 |-> out_word.text_char == 7'h37, "version digit is not seven")

endmodule

bind uuid_v7_text_generator_core uuid7_checker u_chk (.*);
